[sv/disjoint_range_table_core_macros.svh]
// Assertion macros for the range table checker.
`ifndef DISJOINT_RANGE_TABLE_CORE_MACROS_SVH
`define DISJOINT_RANGE_TABLE_CORE_MACROS_SVH

// A condition implies a consequence in the same cycle.
`define DRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("range table check failed");

// A condition implies a consequence in the next cycle.
`define DRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("range table check failed");

`endif

[sv/drt_pkg.sv]
package drt_pkg;

  localparam int unsigned EntriesDef  = 64;
  localparam int unsigned AddrBitsDef = 64;

  typedef enum logic [3:0] {
    CMD_ADD        = 4'd0,
    CMD_REMOVE     = 4'd1,
    CMD_FIND       = 4'd2,
    CMD_FIRST_OVL  = 4'd3,
    CMD_FIND_HOLE  = 4'd4,
    CMD_SHRINK     = 4'd5,
    CMD_SPLIT      = 4'd6,
    CMD_MERGE_PREV = 4'd7,
    CMD_MERGE_NEXT = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IN_USE    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD       = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic rd_own;
    logic scan_init;
    logic scan;
    logic dec;
    logic wr1;
    logic wr2;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_sts_t;

endpackage

[sv/drt_ctrl.sv]
module drt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  drt_pkg::dp_sts_t   sts_i,
  output drt_pkg::ctrl_cmd_t cmd_o,
  output logic               idle_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_RDW   = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_DRAIN = 9'b000010000,
    S_DEC   = 9'b000100000,
    S_WR1   = 9'b001000000,
    S_WR2   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_own = 1'b1;
        state_d      = S_RDW;
      end
      S_RDW: begin
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_DEC;
      S_DEC: begin
        cmd_o.dec = 1'b1;
        state_d   = S_WR1;
      end
      S_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = S_WR2;
      end
      S_WR2: begin
        cmd_o.wr2 = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign idle_o = (state_q == S_IDLE);

endmodule

[sv/drt_dp.sv]
module drt_dp #(
  parameter int unsigned USABLE = 64,
  parameter int unsigned AW     = 64,
  parameter int unsigned IW     = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  drt_pkg::ctrl_cmd_t cmd_i,
  output drt_pkg::dp_sts_t   sts_o,
  input  logic [3:0]         command_i,
  input  logic [63:0]        range_lo_i,
  input  logic [63:0]        range_hi_i,
  input  logic [63:0]        query_addr_i,
  input  logic [5:0]         slot_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [5:0]         result_slot_o,
  output logic [63:0]        result_start_o,
  output logic [63:0]        result_end_o
);

  // Latched request.
  logic [3:0]    cmd_q;
  logic [AW-1:0] lo_q, hi_q, qa_q;
  logic [5:0]    slot_q;

  // Table storage.
  logic [USABLE-1:0] valid_q;
  logic [AW-1:0]     mem_s [USABLE];
  logic [AW-1:0]     mem_e [USABLE];
  logic [AW-1:0]     rd_s_q, rd_e_q;
  logic              rd_v_q;
  logic [IW-1:0]     rd_addr;

  // Scan control.
  logic [IW-1:0] idx_q, ei_q;
  logic          eval_q;

  // Own entry.
  logic [AW-1:0] own_s_q, own_e_q;

  // Scan accumulators.
  logic          fr_f_q, hd_f_q, ov_f_q, pv_f_q, nx_f_q;
  logic [IW-1:0] fr_i_q, hd_i_q, ov_i_q, pv_i_q, nx_i_q;
  logic [AW-1:0] hd_s_q, hd_e_q, ov_s_q, ov_e_q, pv_s_q, pv_e_q, nx_s_q, nx_e_q;
  logic [AW-1:0] hs_q, he_q;

  // Result and write plan.
  drt_pkg::status_e res_st_q, d_st;
  logic [5:0]       res_slot_q, d_slot;
  logic [AW-1:0]    res_a_q, res_b_q, d_a, d_b;
  logic             ws_en_q, e1_en_q, e2_en_q, d_ws_en, d_e1_en, d_e2_en;
  logic [IW-1:0]    ws_i_q, e1_i_q, e2_i_q, d_ws_i, d_e1_i, d_e2_i;
  logic [AW-1:0]    ws_d_q, e1_d_q, e2_d_q, d_ws_d, d_e1_d, d_e2_d;
  logic             d_vset, d_vclr;
  logic [IW-1:0]    d_vset_i, d_vclr_i;

  // Output register.
  logic             out_valid_q;
  logic [2:0]       out_st_q;
  logic [5:0]       out_slot_q;
  logic [AW-1:0]    out_a_q, out_b_q;

  logic          slot_in;
  logic [IW-1:0] sidx;
  logic          hok;
  logic [AW-1:0] e_inc, s_dec, pv_inc, nx_dec, qa_dec;

  assign slot_in = ({1'b0, slot_q} < 7'(USABLE));
  assign sidx    = slot_q[IW-1:0];
  assign hok     = slot_in && valid_q[sidx];
  assign rd_addr = cmd_i.rd_own ? (slot_in ? sidx : '0) : idx_q;
  assign e_inc   = rd_e_q + AW'(1);
  assign s_dec   = rd_s_q - AW'(1);
  assign pv_inc  = pv_e_q + AW'(1);
  assign nx_dec  = nx_s_q - AW'(1);
  assign qa_dec  = qa_q - AW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= command_i;
      lo_q   <= range_lo_i[AW-1:0];
      hi_q   <= range_hi_i[AW-1:0];
      qa_q   <= query_addr_i[AW-1:0];
      slot_q <= slot_i;
    end
  end

  // Memories: one registered read port and one write port each.
  always_ff @(posedge clk_i) begin
    rd_s_q <= mem_s[rd_addr];
    rd_e_q <= mem_e[rd_addr];
    rd_v_q <= valid_q[rd_addr];
    if (cmd_i.wr1 && ws_en_q) mem_s[ws_i_q] <= ws_d_q;
    if (cmd_i.wr1 && e1_en_q) mem_e[e1_i_q] <= e1_d_q;
    else if (cmd_i.wr2 && e2_en_q) mem_e[e2_i_q] <= e2_d_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      eval_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      eval_q <= cmd_i.scan;
      if (cmd_i.scan_init) idx_q <= '0;
      else if (cmd_i.scan) idx_q <= idx_q + IW'(1);
      if (cmd_i.dec && d_vset) valid_q[d_vset_i] <= 1'b1;
      if (cmd_i.dec && d_vclr) valid_q[d_vclr_i] <= 1'b0;
    end
  end

  assign sts_o.scan_last = (idx_q == IW'(USABLE - 1));
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    ei_q <= idx_q;
    if (cmd_i.scan_init) begin
      own_s_q <= rd_s_q;
      own_e_q <= rd_e_q;
      fr_f_q  <= 1'b0;
      hd_f_q  <= 1'b0;
      ov_f_q  <= 1'b0;
      pv_f_q  <= 1'b0;
      nx_f_q  <= 1'b0;
      hs_q    <= '0;
      he_q    <= '1;
    end else if (eval_q) begin
      if (!rd_v_q && !fr_f_q) begin
        fr_f_q <= 1'b1;
        fr_i_q <= ei_q;
      end
      if (rd_v_q && !hd_f_q && rd_s_q <= qa_q && qa_q <= rd_e_q) begin
        hd_f_q <= 1'b1;
        hd_i_q <= ei_q;
        hd_s_q <= rd_s_q;
        hd_e_q <= rd_e_q;
      end
      if (rd_v_q && rd_s_q <= hi_q && rd_e_q >= lo_q && (!ov_f_q || rd_s_q < ov_s_q)) begin
        ov_f_q <= 1'b1;
        ov_i_q <= ei_q;
        ov_s_q <= rd_s_q;
        ov_e_q <= rd_e_q;
      end
      if (rd_v_q && rd_e_q < qa_q && e_inc > hs_q) hs_q <= e_inc;
      if (rd_v_q && rd_s_q > qa_q && s_dec < he_q) he_q <= s_dec;
      if (rd_v_q && rd_s_q < own_s_q && (!pv_f_q || rd_s_q > pv_s_q)) begin
        pv_f_q <= 1'b1;
        pv_i_q <= ei_q;
        pv_s_q <= rd_s_q;
        pv_e_q <= rd_e_q;
      end
      if (rd_v_q && rd_s_q > own_s_q && (!nx_f_q || rd_s_q < nx_s_q)) begin
        nx_f_q <= 1'b1;
        nx_i_q <= ei_q;
        nx_s_q <= rd_s_q;
        nx_e_q <= rd_e_q;
      end
    end
  end

  // Decision once the scan is done.
  always_comb begin
    d_st     = drt_pkg::ST_BAD;
    d_slot   = '0;
    d_a      = '0;
    d_b      = '0;
    d_ws_en  = 1'b0;
    d_ws_i   = sidx;
    d_ws_d   = lo_q;
    d_e1_en  = 1'b0;
    d_e1_i   = sidx;
    d_e1_d   = hi_q;
    d_e2_en  = 1'b0;
    d_e2_i   = sidx;
    d_e2_d   = qa_dec;
    d_vset   = 1'b0;
    d_vset_i = fr_i_q;
    d_vclr   = 1'b0;
    d_vclr_i = sidx;
    unique case (drt_pkg::cmd_e'(cmd_q))
      drt_pkg::CMD_ADD: begin
        if (lo_q <= hi_q) begin
          if (ov_f_q) begin
            d_st = drt_pkg::ST_IN_USE;
          end else if (!fr_f_q) begin
            d_st = drt_pkg::ST_FULL;
          end else begin
            d_st    = drt_pkg::ST_OK;
            d_slot  = 6'(fr_i_q);
            d_a     = lo_q;
            d_b     = hi_q;
            d_vset  = 1'b1;
            d_ws_en = 1'b1;
            d_ws_i  = fr_i_q;
            d_e1_en = 1'b1;
            d_e1_i  = fr_i_q;
          end
        end
      end
      drt_pkg::CMD_REMOVE: begin
        if (hok) begin
          d_st   = drt_pkg::ST_OK;
          d_slot = slot_q;
          d_a    = own_s_q;
          d_b    = own_e_q;
          d_vclr = 1'b1;
        end
      end
      drt_pkg::CMD_FIND: begin
        if (hd_f_q) begin
          d_st   = drt_pkg::ST_OK;
          d_slot = 6'(hd_i_q);
          d_a    = hd_s_q;
          d_b    = hd_e_q;
        end else begin
          d_st = drt_pkg::ST_NOT_FOUND;
        end
      end
      drt_pkg::CMD_FIRST_OVL: begin
        if (lo_q <= hi_q) begin
          if (ov_f_q) begin
            d_st   = drt_pkg::ST_OK;
            d_slot = 6'(ov_i_q);
            d_a    = ov_s_q;
            d_b    = ov_e_q;
          end else begin
            d_st = drt_pkg::ST_NOT_FOUND;
          end
        end
      end
      drt_pkg::CMD_FIND_HOLE: begin
        if (lo_q <= qa_q && qa_q <= hi_q) begin
          if (hd_f_q) begin
            d_st = drt_pkg::ST_IN_USE;
          end else begin
            d_st = drt_pkg::ST_OK;
            d_a  = (lo_q > hs_q) ? lo_q : hs_q;
            d_b  = (hi_q < he_q) ? hi_q : he_q;
          end
        end
      end
      drt_pkg::CMD_SHRINK: begin
        if (hok && lo_q <= hi_q && own_s_q <= lo_q && own_e_q >= hi_q) begin
          d_st    = drt_pkg::ST_OK;
          d_slot  = slot_q;
          d_a     = lo_q;
          d_b     = hi_q;
          d_ws_en = 1'b1;
          d_e1_en = 1'b1;
        end
      end
      drt_pkg::CMD_SPLIT: begin
        if (hok && qa_q > own_s_q && qa_q <= own_e_q) begin
          if (!fr_f_q) begin
            d_st = drt_pkg::ST_FULL;
          end else begin
            d_st    = drt_pkg::ST_OK;
            d_slot  = 6'(fr_i_q);
            d_a     = qa_q;
            d_b     = own_e_q;
            d_vset  = 1'b1;
            d_ws_en = 1'b1;
            d_ws_i  = fr_i_q;
            d_ws_d  = qa_q;
            d_e1_en = 1'b1;
            d_e1_i  = fr_i_q;
            d_e1_d  = own_e_q;
            d_e2_en = 1'b1;
          end
        end
      end
      drt_pkg::CMD_MERGE_PREV: begin
        if (hok) begin
          if (pv_f_q && pv_inc == own_s_q) begin
            d_st     = drt_pkg::ST_OK;
            d_slot   = 6'(pv_i_q);
            d_a      = pv_s_q;
            d_b      = own_e_q;
            d_vclr   = 1'b1;
            d_vclr_i = pv_i_q;
            d_ws_en  = 1'b1;
            d_ws_d   = pv_s_q;
          end else begin
            d_st = drt_pkg::ST_NOT_FOUND;
          end
        end
      end
      drt_pkg::CMD_MERGE_NEXT: begin
        if (hok) begin
          if (nx_f_q && nx_dec == own_e_q) begin
            d_st     = drt_pkg::ST_OK;
            d_slot   = 6'(nx_i_q);
            d_a      = own_s_q;
            d_b      = nx_e_q;
            d_vclr   = 1'b1;
            d_vclr_i = nx_i_q;
            d_e1_en  = 1'b1;
            d_e1_d   = nx_e_q;
          end else begin
            d_st = drt_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: d_st = drt_pkg::ST_BAD;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec) begin
      res_st_q   <= d_st;
      res_slot_q <= d_slot;
      res_a_q    <= d_a;
      res_b_q    <= d_b;
      ws_i_q     <= d_ws_i;
      ws_d_q     <= d_ws_d;
      e1_i_q     <= d_e1_i;
      e1_d_q     <= d_e1_d;
      e2_i_q     <= d_e2_i;
      e2_d_q     <= d_e2_d;
    end
    if (cmd_i.load_out) begin
      out_st_q   <= res_st_q;
      out_slot_q <= res_slot_q;
      out_a_q    <= res_a_q;
      out_b_q    <= res_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_en_q     <= 1'b0;
      e1_en_q     <= 1'b0;
      e2_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.dec) begin
        ws_en_q <= d_ws_en;
        e1_en_q <= d_e1_en;
        e2_en_q <= d_e2_en;
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign result_slot_o  = out_slot_q;
  assign result_start_o = 64'(out_a_q);
  assign result_end_o   = 64'(out_b_q);

endmodule

[sv/disjoint_range_table_core.sv]
// A request's result is offered after the own-entry read, the scan over all slots, the decision and the table writes.
// The block works on one request at a time; the single-port entry scan sets the pace.
// A new request is taken while a finished result still waits in the output register.
// Reset (rst_ni low, asynchronous) clears all valid bits, the controller and the output
// valid; the stored range bounds are left as they were and need no clearing pass.
module disjoint_range_table_core #(
  parameter int unsigned ENTRIES   = drt_pkg::EntriesDef,
  parameter int unsigned ADDR_BITS = drt_pkg::AddrBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  command_i,
  input  logic [63:0] range_lo_i,
  input  logic [63:0] range_hi_i,
  input  logic [63:0] query_addr_i,
  input  logic [5:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [5:0]  result_slot_o,
  output logic [63:0] result_start_o,
  output logic [63:0] result_end_o
);

  // A handle is six bits wide, so at most 64 slots are ever used.
  localparam int unsigned Usable = (ENTRIES > 64) ? 64 : ENTRIES;
  localparam int unsigned Iw     = $clog2(Usable);

  drt_pkg::ctrl_cmd_t cmd;
  drt_pkg::dp_sts_t   sts;
  logic               idle;
  logic               accept;

  // The controller takes a request only when it is back in its idle state.
  assign in_stall_o = !idle;
  assign accept     = in_valid_i && idle;

  // The controller sequences the own-entry read, the scan over all slots, the
  // decision, the table writes and the hand-off to the output register.
  drt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .idle_o  (idle)
  );

  // The datapath holds the table memories, the valid bits, the scan
  // accumulators and the output register.
  drt_dp #(
    .USABLE(Usable),
    .AW    (ADDR_BITS),
    .IW    (Iw)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .command_i     (command_i),
    .range_lo_i    (range_lo_i),
    .range_hi_i    (range_hi_i),
    .query_addr_i  (query_addr_i),
    .slot_i        (slot_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .result_slot_o (result_slot_o),
    .result_start_o(result_start_o),
    .result_end_o  (result_end_o)
  );

endmodule

[sv/drt_chk.sv]
`include "disjoint_range_table_core_macros.svh"

module drt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [5:0]  result_slot_o,
  input logic [63:0] result_start_o,
  input logic [63:0] result_end_o
);

  // A stalled result stays offered.
  `DRT_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // One request at a time: acceptance closes the input.
  `DRT_ASSERT_NXT(a_one_at_a_time, in_valid_i && !in_stall_o, in_stall_o)

  // A failed request carries no slot and no range.
  `DRT_ASSERT_IMP(a_fail_zero, out_valid_o && status_o != drt_pkg::ST_OK,
    result_slot_o == 6'd0 && result_start_o == 64'd0 && result_end_o == 64'd0)

  // Every successful result describes a proper range.
  `DRT_ASSERT_IMP(a_ok_order, out_valid_o && status_o == drt_pkg::ST_OK,
    result_start_o <= result_end_o)

endmodule

bind disjoint_range_table_core drt_chk u_drt_chk (.*);

[sim/tb.sv]
// Self-checking bench for disjoint_range_table_core.
// A driver process feeds requests from a queue, a monitor process checks every
// result against a predictor that keeps its own copy of the range table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import drt_pkg::*;

  localparam int unsigned Slots     = 64;
  localparam longint unsigned TopAddr = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned LongHold  = 400;
  localparam int unsigned DrainWait = 200;
  localparam longint unsigned CycleLimit = 2_000_000;
  localparam logic [3:0] LastCmd = CMD_MERGE_NEXT;

  typedef struct {
    logic [3:0]  cmd;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] addr;
    logic [5:0]  slot;
  } table_req_t;

  typedef struct {
    status_e     status;
    logic [5:0]  slot;
    logic [63:0] first;
    logic [63:0] last;
  } table_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  command_i = '0;
  logic [63:0] range_lo_i = '0;
  logic [63:0] range_hi_i = '0;
  logic [63:0] query_addr_i = '0;
  logic [5:0]  slot_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [5:0]  result_slot_o;
  logic [63:0] result_start_o;
  logic [63:0] result_end_o;

  disjoint_range_table_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .range_lo_i,
    .range_hi_i, .query_addr_i, .slot_i, .out_valid_o, .out_stall_i,
    .status_o, .result_slot_o, .result_start_o, .result_end_o
  );

  // Mirror of the range table, updated as requests are accepted.
  logic        held[Slots];
  logic [63:0] span_lo[Slots];
  logic [63:0] span_hi[Slots];

  table_req_t pending_reqs[$];
  table_rsp_t expected_rsps[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned error_count = 0;
  int unsigned checked = 0;
  int unsigned status_seen[5];
  longint unsigned cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int lowest_free();
    for (int i = 0; i < Slots; i++) begin
      if (!held[i]) return i;
    end
    return -1;
  endfunction

  function automatic int holder(logic [63:0] a);
    for (int i = 0; i < Slots; i++) begin
      if (held[i] && span_lo[i] <= a && a <= span_hi[i]) return i;
    end
    return -1;
  endfunction

  function automatic int first_overlap(logic [63:0] lo, logic [63:0] hi);
    int best;
    best = -1;
    for (int i = 0; i < Slots; i++) begin
      if (held[i] && span_lo[i] <= hi && span_hi[i] >= lo) begin
        if (best < 0 || span_lo[i] < span_lo[best]) best = i;
      end
    end
    return best;
  endfunction

  // Applies one request to the mirror and returns the result it must produce.
  function automatic table_rsp_t apply_request(table_req_t r);
    table_rsp_t rsp;
    int k;
    int s;
    logic [63:0] hs;
    logic [63:0] he;
    rsp = '{ST_BAD, '0, '0, '0};
    s = r.slot;
    case (r.cmd)
      CMD_ADD: begin
        if (r.lo <= r.hi) begin
          if (first_overlap(r.lo, r.hi) >= 0) begin
            rsp.status = ST_IN_USE;
          end else begin
            k = lowest_free();
            if (k < 0) begin
              rsp.status = ST_FULL;
            end else begin
              held[k] = 1'b1;
              span_lo[k] = r.lo;
              span_hi[k] = r.hi;
              rsp = '{ST_OK, 6'(k), r.lo, r.hi};
            end
          end
        end
      end
      CMD_REMOVE: begin
        if (held[s]) begin
          held[s] = 1'b0;
          rsp = '{ST_OK, 6'(s), span_lo[s], span_hi[s]};
        end
      end
      CMD_FIND: begin
        k = holder(r.addr);
        if (k < 0) rsp.status = ST_NOT_FOUND;
        else rsp = '{ST_OK, 6'(k), span_lo[k], span_hi[k]};
      end
      CMD_FIRST_OVL: begin
        if (r.lo <= r.hi) begin
          k = first_overlap(r.lo, r.hi);
          if (k < 0) rsp.status = ST_NOT_FOUND;
          else rsp = '{ST_OK, 6'(k), span_lo[k], span_hi[k]};
        end
      end
      CMD_FIND_HOLE: begin
        if (r.lo <= r.addr && r.addr <= r.hi) begin
          if (holder(r.addr) >= 0) begin
            rsp.status = ST_IN_USE;
          end else begin
            hs = '0;
            he = TopAddr;
            for (int i = 0; i < Slots; i++) begin
              if (held[i]) begin
                if (span_hi[i] < r.addr && span_hi[i] + 64'd1 > hs) hs = span_hi[i] + 64'd1;
                if (span_lo[i] > r.addr && span_lo[i] - 64'd1 < he) he = span_lo[i] - 64'd1;
              end
            end
            if (r.lo > hs) hs = r.lo;
            if (r.hi < he) he = r.hi;
            rsp = '{ST_OK, '0, hs, he};
          end
        end
      end
      CMD_SHRINK: begin
        if (held[s] && r.lo <= r.hi && span_lo[s] <= r.lo && span_hi[s] >= r.hi) begin
          span_lo[s] = r.lo;
          span_hi[s] = r.hi;
          rsp = '{ST_OK, 6'(s), r.lo, r.hi};
        end
      end
      CMD_SPLIT: begin
        if (held[s] && r.addr > span_lo[s] && r.addr <= span_hi[s]) begin
          k = lowest_free();
          if (k < 0) begin
            rsp.status = ST_FULL;
          end else begin
            held[k] = 1'b1;
            span_lo[k] = r.addr;
            span_hi[k] = span_hi[s];
            span_hi[s] = r.addr - 64'd1;
            rsp = '{ST_OK, 6'(k), r.addr, span_hi[k]};
          end
        end
      end
      CMD_MERGE_PREV: begin
        if (held[s]) begin
          k = -1;
          for (int i = 0; i < Slots; i++) begin
            if (held[i] && span_lo[i] < span_lo[s]) begin
              if (k < 0 || span_lo[i] > span_lo[k]) k = i;
            end
          end
          if (k < 0 || span_hi[k] + 64'd1 != span_lo[s]) begin
            rsp.status = ST_NOT_FOUND;
          end else begin
            held[k] = 1'b0;
            span_lo[s] = span_lo[k];
            rsp = '{ST_OK, 6'(k), span_lo[s], span_hi[s]};
          end
        end
      end
      CMD_MERGE_NEXT: begin
        if (held[s]) begin
          k = -1;
          for (int i = 0; i < Slots; i++) begin
            if (held[i] && span_lo[i] > span_lo[s]) begin
              if (k < 0 || span_lo[i] < span_lo[k]) k = i;
            end
          end
          if (k < 0 || span_lo[k] - 64'd1 != span_hi[s]) begin
            rsp.status = ST_NOT_FOUND;
          end else begin
            held[k] = 1'b0;
            span_hi[s] = span_hi[k];
            rsp = '{ST_OK, 6'(k), span_lo[s], span_hi[s]};
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Most addresses fall in a small window on a 16-byte grid, so that ranges
  // collide, touch and split often; a few sit at the top or anywhere at all.
  function automatic logic [63:0] pick_addr();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80) return 64'($urandom_range(255)) * 16 + 64'($urandom_range(15));
    if (roll < 90) return TopAddr - 64'($urandom_range(40));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [5:0] pick_slot();
    if ($urandom_range(99) < 75) return 6'($urandom_range(40));
    return 6'($urandom_range(63));
  endfunction

  function automatic table_req_t random_request();
    table_req_t r;
    int unsigned roll;
    r.lo = pick_addr();
    // Spans are short, and often a whole grid cell so that neighbors touch.
    if ($urandom_range(1) == 0) begin
      r.lo[3:0] = '0;
      r.hi = r.lo + 64'd15;
    end else begin
      r.hi = r.lo + 64'($urandom_range(31));
    end
    if ($urandom_range(19) == 0) r.hi = pick_addr();
    r.addr = pick_addr();
    r.slot = pick_slot();
    roll = $urandom_range(99);
    if (roll < 35) r.cmd = CMD_ADD;
    else if (roll < 47) r.cmd = CMD_REMOVE;
    else if (roll < 57) r.cmd = CMD_FIND;
    else if (roll < 65) r.cmd = CMD_FIRST_OVL;
    else if (roll < 73) r.cmd = CMD_FIND_HOLE;
    else if (roll < 80) r.cmd = CMD_SHRINK;
    else if (roll < 88) r.cmd = CMD_SPLIT;
    else if (roll < 93) r.cmd = CMD_MERGE_PREV;
    else if (roll < 98) r.cmd = CMD_MERGE_NEXT;
    else r.cmd = 4'($urandom_range(15, LastCmd + 1));
    // Find-hole bounds are usually opened around the query address.
    if (r.cmd == CMD_FIND_HOLE && $urandom_range(3) != 0) begin
      r.lo = (r.addr > 64'd40) ? r.addr - 64'($urandom_range(40)) : '0;
      r.hi = (r.addr < TopAddr - 64'd40) ? r.addr + 64'($urandom_range(40)) : TopAddr;
    end
    return r;
  endfunction

  task automatic queue_request(logic [3:0] cmd, logic [63:0] lo, logic [63:0] hi,
                               logic [63:0] addr, logic [5:0] slot);
    pending_reqs.push_back('{cmd, lo, hi, addr, slot});
  endtask

  // Holds until the driver has sent everything and every result is back.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  // Driver: a request stays on the ports until it is taken, then the next
  // one from the queue may follow, or the channel idles.
  always @(posedge clk_i or negedge rst_ni) begin
    table_req_t cur;
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        cur = '{command_i, range_lo_i, range_hi_i, query_addr_i, slot_i};
        expected_rsps.push_back(apply_request(cur));
        void'(pending_reqs.pop_front());
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i   <= 1'b1;
          command_i    <= pending_reqs[0].cmd;
          range_lo_i   <= pending_reqs[0].lo;
          range_hi_i   <= pending_reqs[0].hi;
          query_addr_i <= pending_reqs[0].addr;
          slot_i       <= pending_reqs[0].slot;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random back-pressure, or a long hold when one is asked for.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done  <= holds_asked;
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    table_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result status %0d slot %0d range %h..%h", $time,
                 status_o, result_slot_o, result_start_o, result_end_o);
      end else begin
        want = expected_rsps.pop_front();
        checked++;
        if (status_o < 3'd5) status_seen[status_o]++;
        if (status_o !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
        end
        if (result_slot_o !== want.slot) begin
          error_count++;
          $display("%0t: slot expected %0d got %0d", $time, want.slot, result_slot_o);
        end
        if (result_start_o !== want.first) begin
          error_count++;
          $display("%0t: start expected %h got %h", $time, want.first, result_start_o);
        end
        if (result_end_o !== want.last) begin
          error_count++;
          $display("%0t: end expected %h got %h", $time, want.last, result_end_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      held[i] = 1'b0;
      span_lo[i] = '0;
      span_hi[i] = '0;
    end
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass: each command, its error cases and the address extremes.
    queue_request(CMD_ADD, 64'h100, 64'h1FF, '0, '0);
    queue_request(CMD_ADD, '0, '0, '0, '0);
    queue_request(CMD_ADD, TopAddr, TopAddr, '0, '0);
    queue_request(CMD_ADD, 64'h180, 64'h190, '0, '0);
    queue_request(CMD_ADD, 64'd5, 64'd4, '0, '0);
    queue_request(CMD_FIND, '0, '0, 64'h150, '0);
    queue_request(CMD_FIND, '0, '0, TopAddr, 6'h3F);
    queue_request(CMD_FIND, '0, '0, 64'h50, '0);
    queue_request(CMD_FIRST_OVL, '0, TopAddr, '0, '0);
    queue_request(CMD_FIRST_OVL, 64'h200, 64'h300, '0, '0);
    queue_request(CMD_FIND_HOLE, '0, TopAddr, 64'h50, '0);
    queue_request(CMD_FIND_HOLE, '0, TopAddr, 64'h100, '0);
    queue_request(CMD_FIND_HOLE, 64'd6, TopAddr, 64'd5, '0);
    queue_request(CMD_SHRINK, 64'h110, 64'h1F0, '0, 6'd0);
    queue_request(CMD_SHRINK, 64'h100, 64'h1F0, '0, 6'd0);
    queue_request(CMD_SPLIT, '0, '0, 64'h180, 6'd0);
    queue_request(CMD_SPLIT, '0, '0, 64'h110, 6'd0);
    queue_request(CMD_MERGE_NEXT, '0, '0, '0, 6'd0);
    queue_request(CMD_SPLIT, '0, '0, 64'h150, 6'd0);
    queue_request(CMD_MERGE_PREV, '0, '0, '0, 6'd3);
    queue_request(CMD_MERGE_PREV, '0, '0, '0, 6'd1);
    queue_request(CMD_REMOVE, '0, '0, '0, 6'h3F);
    queue_request(CMD_REMOVE, '0, '0, '0, 6'd3);
    queue_request(4'hF, TopAddr, TopAddr, TopAddr, 6'h3F);
    queue_request(CMD_ADD, '0, TopAddr, '0, '0);
    wait_drained();

    // Random phases, each drained before the next so the sender pauses.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin
          // Long receiver hold while the sender keeps offering requests.
          send_idle_pct = 0;
          recv_stall_pct = 0;
          holds_asked++;
        end
      endcase
      repeat (335) pending_reqs.push_back(random_request());
      wait_drained();
    end

    repeat (DrainWait) @(posedge clk_i);
    $display("Checked %0d results: %0d ok, %0d in use, %0d not found, %0d full, %0d bad",
             checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    $display("Phases covered free flow, sender gaps, receiver stalls, both, and a long hold.");
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/drt_pkg.sv
sv/drt_ctrl.sv
sv/drt_dp.sv
sv/disjoint_range_table_core.sv
sv/drt_chk.sv
sim/tb.sv
